// ----- rtl/core/idq_pkg.sv -----
// Package for the indexed deque store: sizes, command and status codes,
// and the packed item and result types shared by all modules of the block.
// No dependencies.
package idq_pkg;

    // Store geometry
    localparam int MAX_ENTRIES = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths on the streams
    localparam int CAP_W    = 5;
    localparam int LEN_W    = 5;
    localparam int ODATA_W  = 32;
    localparam int IVALUE_W = 32;

    // Command codes; code 7 is unused and acts as a no-op
    localparam logic [2:0] CMD_ADD_BACK  = 3'd0;
    localparam logic [2:0] CMD_ADD_FRONT = 3'd1;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_GET       = 3'd4;
    localparam logic [2:0] CMD_SWAP      = 3'd5;
    localparam logic [2:0] CMD_REWIND    = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // One command item; last field in the lowest bits
    typedef struct packed {
        logic                advance;
        logic [IVALUE_W-1:0] value;
        logic [3:0]          index_b;
        logic [3:0]          index_a;
        logic [2:0]          cmd;
    } item_t;

    // One result item; last field in the lowest bits
    typedef struct packed {
        logic [1:0]         status;
        logic [LEN_W-1:0]   length;
        logic               data_valid;
        logic [ODATA_W-1:0] data;
    } result_t;

    localparam int ITEM_W      = $bits(item_t);
    localparam int RESULT_W    = $bits(result_t);
    localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    typedef logic [DATA_WIDTH-1:0] word_t;

endpackage

// ----- rtl/core/indexed_deque_store.sv -----
// Indexed deque store: a bounded ordered store of up to MAX_ENTRIES words.
//
// Channels: commands arrive on the s_ stream, one result per command leaves
// on the m_ stream. The user must write the capacity register (cfg_wr_en,
// cfg_wr_data) only while the block is idle; the block does not enforce it.
// It limits how many entries an add may create before it reports full.
// Order: a command accepted into the input register is executed when the
// result register has room, and its result is then offered on m_tvalid.
// Throughput: one command per cycle while results drain; the whole command,
// including front shifts and swaps, runs in one pass of the execute stage
// between the input register and the result register.
// Reset: rst_n clears the store, count and cursor, sets capacity to 16 and
// empties both the input and result registers.
// Stalls: when m_tready is low the result is held; the input register, if
// empty, takes one more command, then s_tready drops until the result moves.
// Depends on idq_pkg, idq_in_stage, idq_core and idq_out_stage.
module indexed_deque_store
    import idq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CAP_W-1:0]       cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: cmd[2:0], index_a[6:3], index_b[10:7], value[42:11],
    // advance[43], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: data[31:0], data_valid[32], length[37:33], status[39:38]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic    item_valid;
    item_t   item;
    logic    out_space;
    logic    exec_en;
    result_t result;

    // Execute when a command is held and the result register has room
    assign exec_en = item_valid && out_space;

    idq_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (exec_en),
        .item_valid (item_valid),
        .item       (item)
    );

    idq_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .exec_en     (exec_en),
        .item        (item),
        .result      (result)
    );

    idq_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (exec_en),
        .result   (result),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/core/idq_in_stage.sv -----
// Input register of the indexed deque store: captures one command transfer
// and holds it until the execute stage takes it. Depends on idq_pkg.
module idq_in_stage
    import idq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  take,
    output logic                  item_valid,
    output item_t                 item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/core/idq_core.sv -----
// Execute stage of the indexed deque store: entry array, count, cursor and
// capacity register, plus the combinational command logic. Depends on idq_pkg.
module idq_core
    import idq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             exec_en,
    input  item_t            item,
    output result_t          result
);

    word_t            entries_reg [MAX_ENTRIES];
    word_t            entries_next[MAX_ENTRIES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cursor_reg;
    logic [CNT_W-1:0] cursor_next;
    logic [CAP_W-1:0] capacity_reg;

    logic [CNT_W-1:0] ia;
    logic [CNT_W-1:0] ib;
    logic [CNT_W-1:0] cur_inc;
    logic [CNT_W-1:0] cnt_dec;
    logic             full;
    word_t            val;
    word_t            rd_data;
    logic             rd_valid;
    logic [1:0]       status;

    assign ia      = CNT_W'(item.index_a);
    assign ib      = CNT_W'(item.index_b);
    assign cur_inc = cursor_reg + CNT_W'(1);
    assign cnt_dec = count_reg - CNT_W'(1);
    assign val     = DATA_WIDTH'(item.value);
    assign full    = (32'(count_reg) >= 32'(MAX_ENTRIES))
                  || (32'(count_reg) >= 32'(capacity_reg));

    // Command decode and next state
    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        rd_data      = '0;
        rd_valid     = 1'b0;
        status       = ST_OK;
        if (item.advance)
        begin
            if (cursor_reg >= count_reg)
            begin
                status = ST_BAD;
            end
            else
            begin
                cursor_next = cur_inc;
                if (cur_inc < count_reg)
                begin
                    rd_data  = entries_reg[cur_inc[IDX_W-1:0]];
                    rd_valid = 1'b1;
                end
                else
                begin
                    status = ST_BAD;
                end
            end
        end
        else
        begin
            unique case (item.cmd) inside
                CMD_ADD_BACK, CMD_ADD_FRONT:
                begin
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        if (item.cmd == CMD_ADD_FRONT)
                        begin
                            for (int k = 1; k < MAX_ENTRIES; k++)
                            begin
                                if (k <= 32'(count_reg))
                                begin
                                    entries_next[IDX_W'(k)] = entries_reg[IDX_W'(k - 1)];
                                end
                            end
                            entries_next[0] = val;
                        end
                        else
                        begin
                            entries_next[count_reg[IDX_W-1:0]] = val;
                        end
                        count_next  = count_reg + CNT_W'(1);
                        cursor_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_DEL_BACK, CMD_DEL_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        status = ST_BAD;
                    end
                    else
                    begin
                        if (item.cmd == CMD_DEL_FRONT)
                        begin
                            for (int k = 0; k < MAX_ENTRIES - 1; k++)
                            begin
                                if (k < 32'(cnt_dec))
                                begin
                                    entries_next[IDX_W'(k)] = entries_reg[IDX_W'(k + 1)];
                                end
                            end
                        end
                        entries_next[cnt_dec[IDX_W-1:0]] = '0;
                        count_next  = cnt_dec;
                        cursor_next = cnt_dec;
                    end
                end
                CMD_GET:
                begin
                    if (ia < count_reg)
                    begin
                        rd_data  = entries_reg[ia[IDX_W-1:0]];
                        rd_valid = 1'b1;
                    end
                    else
                    begin
                        status = ST_BAD;
                    end
                end
                CMD_SWAP:
                begin
                    if (ia < count_reg && ib < count_reg)
                    begin
                        entries_next[ia[IDX_W-1:0]] = entries_reg[ib[IDX_W-1:0]];
                        entries_next[ib[IDX_W-1:0]] = entries_reg[ia[IDX_W-1:0]];
                    end
                    else
                    begin
                        status = ST_BAD;
                    end
                end
                CMD_REWIND:
                begin
                    cursor_next = '0;
                    if (count_reg != '0)
                    begin
                        rd_data  = entries_reg[0];
                        rd_valid = 1'b1;
                    end
                    else
                    begin
                        status = ST_BAD;
                    end
                end
                default:
                begin
                    // unused code: no change, status ok
                end
            endcase
        end
    end

    // Result fields
    assign result.data       = ODATA_W'(rd_data);
    assign result.data_valid = rd_valid;
    assign result.length     = LEN_W'(count_next);
    assign result.status     = status;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_ENTRIES; k++)
            begin
                entries_reg[IDX_W'(k)] <= '0;
            end
            count_reg    <= '0;
            cursor_reg   <= '0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            if (exec_en)
            begin
                entries_reg <= entries_next;
                count_reg   <= count_next;
                cursor_reg  <= cursor_next;
            end
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    // Checks
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_ENTRIES))
        else $error("count above store depth");

    a_cursor_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor past end of store");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en && !item.advance && status == ST_OK
            && (item.cmd == CMD_ADD_BACK || item.cmd == CMD_ADD_FRONT)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("successful add did not grow count");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !result.data_valid |-> result.data == '0)
        else $error("data not zero without valid entry");

endmodule

// ----- rtl/core/idq_out_stage.sv -----
// Result register of the indexed deque store: holds one result transfer
// until the receiver takes it. Depends on idq_pkg.
module idq_out_stage
    import idq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  result_t                result,
    output logic                   space,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Room for a new result when empty or when the held one drains now
    assign space      = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_TDATA_W'(result_reg);

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for indexed_deque_store: streams random and directed
// deque commands, predicts every result with a local model of the store.
// Depends on idq_pkg and the indexed_deque_store RTL.
`timescale 1ns / 100ps

module tb;
    import idq_pkg::*;

    // Unused command code; the block treats it as a no-op
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    // Cycles without any transfer before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 60;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata: cmd, index_a, index_b, value, advance, zero fill
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata: data, data_valid, length, status
    logic [OUT_TDATA_W-1:0] m_tdata;

    indexed_deque_store dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 clk = ~clk;

    // Commands waiting to be offered, and results still owed by the block
    item_t   pending_cmds[$];
    result_t expected_results[$];

    // Local copy of the store state
    word_t            model_entries [MAX_ENTRIES];
    int               model_count = 0;
    int               model_cursor = 0;
    logic [CAP_W-1:0] model_capacity = CAP_RESET;

    // Generator-side shadow of the entry count, used to aim indexes
    int gen_count = 0;
    int gen_cap = 16;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_left = 0;
    bit cmd_taken = 1'b0;
    int idle_cycles = 0;

    int errors = 0;
    int cmds_sent = 0;
    int results_seen = 0;
    int status_seen [3] = '{0, 0, 0};
    int max_length = 0;

    // Execute one command on the local store and return its result
    function automatic result_t run_command(item_t c);
        result_t r;
        word_t   tmp;
        int      lim;
        r = '0;
        r.status = ST_OK;
        lim = (int'(model_capacity) > MAX_ENTRIES) ? MAX_ENTRIES : int'(model_capacity);
        if (c.advance)
        begin
            if (model_cursor >= model_count)
                r.status = ST_BAD;
            else
            begin
                model_cursor++;
                if (model_cursor < model_count)
                begin
                    r.data = model_entries[model_cursor];
                    r.data_valid = 1'b1;
                end
                else
                    r.status = ST_BAD;
            end
        end
        else
        begin
            case (c.cmd)
                CMD_ADD_BACK, CMD_ADD_FRONT:
                begin
                    if (model_count >= lim)
                        r.status = ST_FULL;
                    else
                    begin
                        if (c.cmd == CMD_ADD_FRONT)
                        begin
                            for (int k = model_count; k > 0; k--)
                                model_entries[k] = model_entries[k-1];
                            model_entries[0] = c.value;
                        end
                        else
                            model_entries[model_count] = c.value;
                        model_count++;
                        model_cursor = model_count;
                    end
                end
                CMD_DEL_BACK, CMD_DEL_FRONT:
                begin
                    if (model_count == 0)
                        r.status = ST_BAD;
                    else
                    begin
                        model_count--;
                        if (c.cmd == CMD_DEL_FRONT)
                            for (int k = 0; k < model_count; k++)
                                model_entries[k] = model_entries[k+1];
                        model_entries[model_count] = '0;
                        model_cursor = model_count;
                    end
                end
                CMD_GET:
                begin
                    if (int'(c.index_a) < model_count)
                    begin
                        r.data = model_entries[c.index_a];
                        r.data_valid = 1'b1;
                    end
                    else
                        r.status = ST_BAD;
                end
                CMD_SWAP:
                begin
                    if (int'(c.index_a) < model_count && int'(c.index_b) < model_count)
                    begin
                        tmp = model_entries[c.index_a];
                        model_entries[c.index_a] = model_entries[c.index_b];
                        model_entries[c.index_b] = tmp;
                    end
                    else
                        r.status = ST_BAD;
                end
                CMD_REWIND:
                begin
                    model_cursor = 0;
                    if (model_count > 0)
                    begin
                        r.data = model_entries[0];
                        r.data_valid = 1'b1;
                    end
                    else
                        r.status = ST_BAD;
                end
                default: ;
            endcase
        end
        r.length = LEN_W'(model_count);
        return r;
    endfunction

    // Queue one command and keep the shadow count in step
    task automatic queue_cmd(logic [2:0] cmd, logic [3:0] ia, logic [3:0] ib,
                             logic [31:0] value, logic adv);
        item_t it;
        int    lim;
        it.cmd = cmd;
        it.index_a = ia;
        it.index_b = ib;
        it.value = value;
        it.advance = adv;
        lim = (gen_cap > MAX_ENTRIES) ? MAX_ENTRIES : gen_cap;
        if (!adv && (cmd == CMD_ADD_BACK || cmd == CMD_ADD_FRONT) && gen_count < lim)
            gen_count++;
        else if (!adv && (cmd == CMD_DEL_BACK || cmd == CMD_DEL_FRONT) && gen_count > 0)
            gen_count--;
        pending_cmds.push_back(it);
    endtask

    // Mostly in-range index, sometimes anything the field allows
    function automatic logic [3:0] pick_index();
        if (gen_count > 0 && $urandom_range(9) < 8)
            return 4'($urandom_range(gen_count - 1));
        return 4'($urandom_range(15));
    endfunction

    task automatic queue_random(int add_w);
        int          w;
        logic [2:0]  cmd;
        logic [3:0]  ia;
        logic [3:0]  ib;
        w = $urandom_range(99);
        ia = pick_index();
        ib = pick_index();
        if (w < 10)
            cmd = 3'($urandom_range(7));
        else if (w < 10 + add_w)
            cmd = $urandom_range(1) ? CMD_ADD_FRONT : CMD_ADD_BACK;
        else if (w < 60)
            cmd = $urandom_range(1) ? CMD_DEL_FRONT : CMD_DEL_BACK;
        else if (w < 75)
            cmd = CMD_GET;
        else if (w < 88)
            cmd = CMD_SWAP;
        else if (w < 96)
            cmd = CMD_REWIND;
        else
            cmd = CMD_UNUSED;
        queue_cmd(cmd, ia, ib, $urandom, w < 10);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        // result path is two stages deep
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        model_capacity = cap;
        gen_cap = int'(cap);
    endtask

    // Input driver: holds an offer until it is taken, gaps at random
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !cmd_taken)
            s_tvalid <= 1'b1;
        else if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tdata <= IN_TDATA_W'(pending_cmds[0]);
        end
        else
            s_tvalid <= 1'b0;
    end

    // Result receiver: random stalls, plus a counted hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Monitor: check each result transfer, predict each command transfer
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        item_t   it;
        cmd_taken = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result with none pending", longint'(got), longint'(0));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.data !== want.data)
                        report_mismatch("data", longint'(got.data), longint'(want.data));
                    if (got.data_valid !== want.data_valid)
                        report_mismatch("data_valid", longint'(got.data_valid),
                                        longint'(want.data_valid));
                    if (got.length !== want.length)
                        report_mismatch("length", longint'(got.length), longint'(want.length));
                    if (got.status !== want.status)
                        report_mismatch("status", longint'(got.status), longint'(want.status));
                end
            end
            if (s_tvalid && s_tready)
            begin
                it = item_t'(s_tdata[ITEM_W-1:0]);
                want = run_command(it);
                expected_results.push_back(want);
                if (want.status <= ST_BAD)
                    status_seen[want.status]++;
                if (model_count > max_length)
                    max_length = model_count;
                void'(pending_cmds.pop_front());
                cmds_sent++;
                cmd_taken = 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        int caps [8]  = '{16, 1, 31, 0, 5, 2, 16, 9};
        int add_w [8] = '{35, 25, 40, 25, 30, 25, 40, 15};
        int count [8] = '{200, 150, 220, 100, 180, 150, 250, 230};
        int send_mix [4] = '{0, 56, 0, 28};
        int recv_mix [4] = '{0, 0, 56, 28};

        foreach (model_entries[i])
            model_entries[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-store errors, extremes, every command, cursor walk
        queue_cmd(CMD_DEL_BACK, 4'hF, 4'hF, 32'h0, 1'b0);
        queue_cmd(CMD_DEL_FRONT, 4'h0, 4'h0, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(CMD_GET, 4'h0, 4'h0, 32'h0, 1'b0);
        queue_cmd(CMD_SWAP, 4'h0, 4'h0, 32'h0, 1'b0);
        queue_cmd(CMD_REWIND, 4'h0, 4'h0, 32'h0, 1'b0);
        queue_cmd(CMD_UNUSED, 4'hF, 4'hF, 32'hFFFF_FFFF, 1'b1);
        queue_cmd(CMD_UNUSED, 4'hF, 4'hF, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(CMD_ADD_BACK, 4'h0, 4'h0, 32'h0000_0000, 1'b0);
        queue_cmd(CMD_ADD_FRONT, 4'hF, 4'h0, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(CMD_ADD_BACK, 4'h0, 4'hF, 32'hA5A5_A5A5, 1'b0);
        queue_cmd(CMD_ADD_FRONT, 4'h0, 4'h0, 32'h0000_0001, 1'b0);
        queue_cmd(CMD_GET, 4'd3, 4'h0, 32'h0, 1'b0);
        queue_cmd(CMD_GET, 4'hF, 4'h0, 32'h0, 1'b0);
        queue_cmd(CMD_SWAP, 4'd0, 4'd3, 32'h0, 1'b0);
        queue_cmd(CMD_SWAP, 4'd1, 4'hF, 32'h0, 1'b0);
        queue_cmd(CMD_REWIND, 4'h0, 4'h0, 32'h0, 1'b0);
        // step onto the last entry, then onto the end, then past it
        repeat (5)
            queue_cmd(CMD_GET, 4'h0, 4'h0, 32'h0, 1'b1);
        queue_cmd(CMD_DEL_FRONT, 4'h0, 4'h0, 32'h0, 1'b0);
        queue_cmd(CMD_DEL_BACK, 4'h0, 4'h0, 32'h0, 1'b0);
        queue_cmd(CMD_GET, 4'h0, 4'h0, 32'h0, 1'b0);

        // Random phases across capacity settings and idle mixes
        for (int p = 0; p < 8; p++)
        begin
            // sender waits for every outstanding result before reconfiguring
            wait_drained();
            write_capacity(CAP_W'(caps[p]));
            send_idle_pct = send_mix[p % 4];
            recv_stall_pct = recv_mix[p % 4];
            if (p == 0)
                stall_left = HOLDOFF_CYCLES;
            for (int n = 0; n < count[p]; n++)
                queue_random(add_w[p]);
            while (pending_cmds.size() != 0)
                @(posedge clk);
        end

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d commands, %0d results, capacities 0 to 31, four idle mixes",
                 cmds_sent, results_seen);
        $display("Status counts: ok %0d, full %0d, empty/bad/end %0d; peak length %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD], max_length);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
